// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sizes, types and status codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH        = 10;
  localparam int PAYLOAD_BITS = 64;

  localparam int LEVEL_W  = 3;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 4;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam logic [LEVEL_W-1:0] LEVEL_MIN = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(5);

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held in slot registers, sorted by level.
// ----------------------------------------------------------------------------
// Entries are held in level order, highest first, and in arrival order within
// a level. One level comparator and one slot move per cycle do all the work:
// an enqueue walks from the tail towards the head, moving each lower entry
// back by one slot until it finds its place; a dequeue takes the head and
// walks the rest forward one slot a cycle. The block takes no new transfer
// until the result of the last one is registered at the output.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [LEVEL_W-1:0]  in_level,
  input  logic [DATA_W-1:0]   in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [LEVEL_W-1:0]  out_level,
  output logic [DATA_W-1:0]   out_payload,
  output logic [FILL_W-1:0]   out_fill
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_DEQ,
    S_RESP
  } state_t;

  state_t                  state_r;
  logic [LEVEL_W-1:0]      slot_level_r [DEPTH];
  logic [PAYLOAD_BITS-1:0] slot_data_r  [DEPTH];
  logic [CNT_W-1:0]        occ_r;
  logic [IDX_W-1:0]        idx_r;
  logic [LEVEL_W-1:0]      new_level_r;
  logic [PAYLOAD_BITS-1:0] new_data_r;
  status_t                 res_status_r;
  logic [LEVEL_W-1:0]      res_level_r;
  logic [PAYLOAD_BITS-1:0] res_data_r;
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [LEVEL_W-1:0]      out_level_r;
  logic [PAYLOAD_BITS-1:0] out_data_r;
  logic [FILL_W-1:0]       out_fill_r;

  logic [LEVEL_W-1:0]      in_level_clamped;
  logic [IDX_W-1:0]        rd_idx;
  logic [LEVEL_W-1:0]      rd_level;
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic                    rd_lower;
  logic                    deq_last;
  logic                    in_xfer;

  assign in_xfer = in_valid && in_ready;

  always_comb begin
    if (in_level < LEVEL_MIN) begin
      in_level_clamped = LEVEL_MIN;
    end else if (in_level > LEVEL_MAX) begin
      in_level_clamped = LEVEL_MAX;
    end else begin
      in_level_clamped = in_level;
    end
  end

  // shared slot read port and level comparator
  assign rd_idx   = (state_r == S_DEQ) ? idx_r + IDX_W'(1) : idx_r - IDX_W'(1);
  assign rd_level = slot_level_r[rd_idx];
  assign rd_data  = slot_data_r[rd_idx];
  assign rd_lower = rd_level < new_level_r;
  assign deq_last = (CNT_W'(idx_r) + CNT_W'(1)) == occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            new_level_r <= in_level_clamped;
            new_data_r  <= in_payload[PAYLOAD_BITS-1:0];
            if (in_cmd == CMD_ENQ) begin
              res_level_r <= '0;
              res_data_r  <= '0;
              if (occ_r == CNT_W'(DEPTH)) begin
                res_status_r <= ST_FULL;
                state_r      <= S_RESP;
              end else begin
                idx_r   <= occ_r[IDX_W-1:0];
                state_r <= S_ENQ;
              end
            end else begin
              if (occ_r == '0) begin
                res_level_r  <= '0;
                res_data_r   <= '0;
                res_status_r <= ST_EMPTY;
                state_r      <= S_RESP;
              end else begin
                res_level_r <= slot_level_r[0];
                res_data_r  <= slot_data_r[0];
                idx_r       <= '0;
                state_r     <= S_DEQ;
              end
            end
          end
        end
        S_ENQ: begin
          if (idx_r != '0 && rd_lower) begin
            slot_level_r[idx_r] <= rd_level;
            slot_data_r[idx_r]  <= rd_data;
            idx_r               <= idx_r - IDX_W'(1);
          end else begin
            slot_level_r[idx_r] <= new_level_r;
            slot_data_r[idx_r]  <= new_data_r;
            occ_r               <= occ_r + CNT_W'(1);
            res_status_r        <= ST_DONE;
            state_r             <= S_RESP;
          end
        end
        S_DEQ: begin
          if (deq_last) begin
            slot_level_r[idx_r] <= '0;
            occ_r               <= occ_r - CNT_W'(1);
            res_status_r        <= ST_DONE;
            state_r             <= S_RESP;
          end else begin
            slot_level_r[idx_r] <= rd_level;
            slot_data_r[idx_r]  <= rd_data;
            idx_r               <= idx_r + IDX_W'(1);
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_level_r  <= res_level_r;
            out_data_r   <= res_data_r;
            out_fill_r   <= FILL_W'(occ_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_level   = out_level_r;
  assign out_payload = DATA_W'(out_data_r);
  assign out_fill    = out_fill_r;

endmodule

// ===== rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [LEVEL_W-1:0]  out_level,
  input logic [DATA_W-1:0]   out_payload,
  input logic [FILL_W-1:0]   out_fill
);

  // a transfer starts work, so no back-to-back transfers
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_fill == FILL_W'(DEPTH))
    else $error("full rejection with queue not full");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_fill == '0 && out_level == '0 && out_payload == '0)
    else $error("empty rejection with non-zero result");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= LEVEL_MAX)
    else $error("returned level out of range");

  a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_level == '0 && out_payload == '0)
    else $error("full rejection returned data");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_level   (out_level),
  .out_payload (out_payload),
  .out_fill    (out_fill)
);
